FILE: sv/mrvf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrvf_pkg
// Shared types, constants and helpers of the missing-rate variant filter.
// ----------------------------------------------------------------------------
package mrvf_pkg;

    localparam int COUNT_W     = 17;
    localparam int THR_W       = 17;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 17;
    localparam int FRAC_W      = 16;
    localparam int COUNTER_MAX = 131071;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(6554);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MISSING_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CASE_CONTROL_MODE = 1'b1;

    typedef logic [COUNT_W-1:0] count_t;

    typedef struct packed {
        count_t case_samples;
        count_t control_samples;
        count_t missing_in_cases;
        count_t missing_in_controls;
    } counts_t;

    function automatic count_t sat_inc(input count_t x, input count_t cap);
        sat_inc = (x < cap) ? x + count_t'(1) : x;
    endfunction

    function automatic count_t sat_add(input count_t a, input count_t b, input count_t cap);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = (s > {1'b0, cap}) ? cap : s[COUNT_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: sv/mrvf_judge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrvf_judge
// Keep/remove decision for one variant from its final counts.
// ----------------------------------------------------------------------------
module mrvf_judge #(
    parameter logic [16:0] COUNT_CAP = 17'd65536
) (
    input  wire mrvf_pkg::counts_t                  counts,
    input  wire logic [mrvf_pkg::THR_W-1:0]         missing_threshold,
    input  wire logic                               case_control_mode,
    output logic                                    keep_variant,
    output mrvf_pkg::count_t                        missing_total
);
    import mrvf_pkg::*;

    localparam int PROD_W = COUNT_W + THR_W;

    count_t sample_total;
    logic   fail_all;
    logic   fail_case;
    logic   fail_control;

    // m/n > t  <=>  m * 2^16 > t * n, so an empty class never fails
    function automatic logic frac_fails(input count_t missing, input count_t total,
                                        input logic [THR_W-1:0] thr);
        logic [PROD_W-1:0] lhs;
        logic [PROD_W-1:0] rhs;
        lhs = PROD_W'({missing, {FRAC_W{1'b0}}});
        rhs = PROD_W'(thr) * PROD_W'(total);
        frac_fails = lhs > rhs;
    endfunction

    always_comb begin
        missing_total = sat_add(counts.missing_in_cases, counts.missing_in_controls, COUNT_CAP);
        sample_total  = sat_add(counts.case_samples, counts.control_samples, COUNT_CAP);
        fail_all      = frac_fails(missing_total, sample_total, missing_threshold);
        fail_case     = frac_fails(counts.missing_in_cases, counts.case_samples,
                                   missing_threshold);
        fail_control  = frac_fails(counts.missing_in_controls, counts.control_samples,
                                   missing_threshold);
        if (case_control_mode) begin
            keep_variant = !fail_case && !fail_control;
        end else begin
            keep_variant = !fail_all;
        end
    end

endmodule
`default_nettype wire

FILE: sv/missing_rate_variant_filter.sv
// A last-sample word is captured in the snapshot register, then judged into the result register.
// Throughput: one sample word per cycle while s_ready is high; non-last words produce no result.
// Samples are counted in the counter registers, the snapshot register feeds the compare (17x17 multiply)
// that loads the result register; a stalled result word holds the input only once
// the snapshot register is also full.
// Reset clears all counters, empties the pipeline, restores threshold 6554, pooled mode.
`default_nettype none
// ----------------------------------------------------------------------------
// missing_rate_variant_filter
// Counts missing genotype calls per class over one variant's samples and
// flags whether the variant passes the missing-rate threshold.
// ----------------------------------------------------------------------------
module missing_rate_variant_filter #(
    parameter int unsigned MAX_SAMPLES = 65536
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // configuration writes
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [mrvf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [mrvf_pkg::CFG_DATA_W-1:0]       cfg_data,
    // sample words
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic                                  s_call_missing,
    input  wire logic                                  s_is_case,
    input  wire logic                                  s_last_sample,
    // decision words
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic                                       m_keep_variant,
    output logic [mrvf_pkg::COUNT_W-1:0]               m_missing_total
);
    import mrvf_pkg::*;

    localparam count_t COUNT_CAP = (MAX_SAMPLES < COUNTER_MAX) ?
                                   COUNT_W'(MAX_SAMPLES) : COUNT_W'(COUNTER_MAX);

    logic [THR_W-1:0] threshold_reg;
    logic             mode_reg;

    counts_t counts_reg;
    counts_t counts_next;
    counts_t snap_reg;
    logic    snap_valid_reg;
    logic    m_valid_reg;
    logic    keep_reg;
    count_t  missing_total_reg;

    logic    s_accept;
    logic    out_ready;
    logic    judge_keep;
    count_t  judge_missing;

    assign cfg_ready = 1'b1;
    assign out_ready = !m_valid_reg || m_ready;
    assign s_ready   = !snap_valid_reg || out_ready;
    assign s_accept  = s_valid && s_ready;

    assign m_valid         = m_valid_reg;
    assign m_keep_variant  = keep_reg;
    assign m_missing_total = missing_total_reg;

    always_comb begin
        counts_next = counts_reg;
        if (s_is_case) begin
            counts_next.case_samples = sat_inc(counts_reg.case_samples, COUNT_CAP);
            if (s_call_missing) begin
                counts_next.missing_in_cases = sat_inc(counts_reg.missing_in_cases, COUNT_CAP);
            end
        end else begin
            counts_next.control_samples = sat_inc(counts_reg.control_samples, COUNT_CAP);
            if (s_call_missing) begin
                counts_next.missing_in_controls =
                    sat_inc(counts_reg.missing_in_controls, COUNT_CAP);
            end
        end
    end

    mrvf_judge #(
        .COUNT_CAP(COUNT_CAP)
    ) u_judge (
        .counts            (snap_reg),
        .missing_threshold (threshold_reg),
        .case_control_mode (mode_reg),
        .keep_variant      (judge_keep),
        .missing_total     (judge_missing)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg  <= THRESHOLD_RESET;
            mode_reg       <= 1'b0;
            counts_reg     <= '0;
            snap_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_MISSING_THRESHOLD: threshold_reg <= THR_W'(cfg_data);
                    REG_CASE_CONTROL_MODE: mode_reg      <= cfg_data[0];
                    default: ;
                endcase
            end
            // drop the counts once the last sample has been captured
            if (s_accept) begin
                counts_reg <= s_last_sample ? '0 : counts_next;
            end
            if (s_ready) begin
                snap_valid_reg <= s_accept && s_last_sample;
            end
            if (out_ready) begin
                m_valid_reg <= snap_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && s_last_sample) begin
            snap_reg <= counts_next;
        end
        if (out_ready && snap_valid_reg) begin
            keep_reg          <= judge_keep;
            missing_total_reg <= judge_missing;
        end
    end

    a_snap_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_last_sample |=> snap_valid_reg)
        else $error("last sample did not load the snapshot stage");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_last_sample |=> counts_reg == '0)
        else $error("counters not cleared after last sample");

    a_missing_case_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        counts_reg.missing_in_cases <= counts_reg.case_samples)
        else $error("case missing count exceeds case samples");

    a_missing_control_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        counts_reg.missing_in_controls <= counts_reg.control_samples)
        else $error("control missing count exceeds control samples");

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        counts_reg.case_samples <= COUNT_CAP && counts_reg.control_samples <= COUNT_CAP)
        else $error("sample counter passed its cap");

endmodule
`default_nettype wire

FILE: bench/mrvf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrvf_checker
// Watches the register, sample and decision channels of the missing-rate
// variant filter. It keeps its own copy of the registers and the per-variant
// counters, predicts each decision word, and compares the decisions in order.
// ----------------------------------------------------------------------------
module mrvf_checker #(
    parameter int unsigned MAX_SAMPLES = 65536
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [mrvf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mrvf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic                           s_call_missing,
    input  logic                           s_is_case,
    input  logic                           s_last_sample,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic                           m_keep_variant,
    input  logic [mrvf_pkg::COUNT_W-1:0]    m_missing_total,
    output int                             errors,
    output int                             pending
);
    import mrvf_pkg::*;

    localparam longint unsigned SAT_LIMIT =
        (MAX_SAMPLES < COUNTER_MAX) ? MAX_SAMPLES : COUNTER_MAX;
    localparam count_t COUNT_CAP = count_t'(SAT_LIMIT);
    localparam longint unsigned FULL_SCALE = 65536;

    typedef struct packed {
        logic   keep;
        count_t missing_total;
    } decision_t;

    logic [THR_W-1:0] threshold;
    logic             pooled_n;     // 1: cases and controls tested apart
    count_t           n_case;
    count_t           n_control;
    count_t           miss_case;
    count_t           miss_control;
    decision_t        decisions_due[$];

    initial errors = 0;

    function automatic count_t count_up(input count_t x);
        return (x < COUNT_CAP) ? x + count_t'(1) : x;
    endfunction

    function automatic count_t capped_sum(input count_t a, input count_t b);
        longint unsigned s;
        s = 64'(a) + 64'(b);
        return (s > SAT_LIMIT) ? COUNT_CAP : count_t'(s);
    endfunction

    // cross-multiply so an empty class can never fail
    function automatic logic rate_too_high(input count_t missing, input count_t total);
        return (64'(missing) * FULL_SCALE) > (64'(threshold) * 64'(total));
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    always @(posedge aclk) begin : watch
        decision_t want;
        count_t    sum_missing;
        if (!aresetn) begin
            threshold    = THRESHOLD_RESET;
            pooled_n     = 1'b0;
            n_case       = '0;
            n_control    = '0;
            miss_case    = '0;
            miss_control = '0;
            decisions_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MISSING_THRESHOLD: threshold = cfg_data[THR_W-1:0];
                    REG_CASE_CONTROL_MODE: pooled_n = cfg_data[0];
                    default: ;
                endcase
            end

            if (m_valid && m_ready) begin
                if (decisions_due.size() == 0) begin
                    report_mismatch($sformatf("decision word with none due (keep %0b total %0d)",
                                              m_keep_variant, m_missing_total));
                end else begin
                    want = decisions_due.pop_front();
                    if (m_keep_variant !== want.keep)
                        report_mismatch($sformatf("keep_variant got %0b expected %0b",
                                                  m_keep_variant, want.keep));
                    if (m_missing_total !== want.missing_total)
                        report_mismatch($sformatf("missing_total got %0d expected %0d",
                                                  m_missing_total, want.missing_total));
                end
            end

            if (s_valid && s_ready) begin
                if (s_is_case) begin
                    n_case = count_up(n_case);
                    if (s_call_missing)
                        miss_case = count_up(miss_case);
                end else begin
                    n_control = count_up(n_control);
                    if (s_call_missing)
                        miss_control = count_up(miss_control);
                end
                if (s_last_sample) begin
                    sum_missing = capped_sum(miss_case, miss_control);
                    if (pooled_n)
                        want.keep = !rate_too_high(miss_case, n_case) &&
                                    !rate_too_high(miss_control, n_control);
                    else
                        want.keep = !rate_too_high(sum_missing,
                                                   capped_sum(n_case, n_control));
                    want.missing_total = sum_missing;
                    decisions_due.insert(decisions_due.size(), want);
                    n_case       = '0;
                    n_control    = '0;
                    miss_case    = '0;
                    miss_control = '0;
                end
            end
        end
        pending <= decisions_due.size();
    end

endmodule

FILE: bench/missing_rate_variant_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// missing_rate_variant_filter_tb
// Streams variants of sample words into the filter under changing thresholds
// and modes, with random gaps and stalls, and lets the checker judge every
// decision word.
// ----------------------------------------------------------------------------
module missing_rate_variant_filter_tb;
    import mrvf_pkg::*;

    localparam int unsigned MAX_SAMPLES = 65536;

    logic                  aclk           = 1'b0;
    logic                  aresetn        = 1'b0;
    logic                  cfg_valid      = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index      = REG_MISSING_THRESHOLD;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;
    logic                  s_valid        = 1'b0;
    logic                  s_ready;
    logic                  s_call_missing = 1'b0;
    logic                  s_is_case      = 1'b0;
    logic                  s_last_sample  = 1'b0;
    logic                  m_valid;
    logic                  m_ready        = 1'b0;
    logic                  m_keep_variant;
    logic [COUNT_W-1:0]    m_missing_total;

    int errors;
    int pending;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int n_words     = 0;
    int n_variants  = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    missing_rate_variant_filter #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_call_missing (s_call_missing),
        .s_is_case      (s_is_case),
        .s_last_sample  (s_last_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_keep_variant (m_keep_variant),
        .m_missing_total(m_missing_total)
    );

    mrvf_checker #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) decision_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_call_missing (s_call_missing),
        .s_is_case      (s_is_case),
        .s_last_sample  (s_last_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_keep_variant (m_keep_variant),
        .m_missing_total(m_missing_total),
        .errors         (errors),
        .pending        (pending)
    );

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // drop valid and hold until every decision due has come back
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        hold_until_drained();
        repeat (3) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_filter(input int thr, input logic per_class);
        write_reg(REG_MISSING_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(REG_CASE_CONTROL_MODE, CFG_DATA_W'(per_class));
    endtask

    task automatic send_sample(input logic miss, input logic cls, input logic last);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid        <= 1'b1;
        s_call_missing <= miss;
        s_is_case      <= cls;
        s_last_sample  <= last;
        do @(posedge aclk); while (!s_ready);
        n_words++;
        if (last)
            n_variants++;
    endtask

    function automatic int pick_threshold();
        case ($urandom_range(5))
            0:       return 0;
            1:       return 65536;
            2:       return 131071;
            3:       return $urandom_range(65536);
            4:       return $urandom_range(131071, 65537);
            default: return $urandom_range(20000);
        endcase
    endfunction

    task automatic random_segment(input int n_items);
        int sent;
        int len;
        int miss_pct;
        int case_pct;
        sent = 0;
        set_filter(pick_threshold(), $urandom_range(1));
        while (sent < n_items) begin
            len      = ($urandom_range(9) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 1);
            miss_pct = $urandom_range(100);
            case_pct = $urandom_range(100);
            for (int i = 0; i < len; i++)
                send_sample($urandom_range(99) < miss_pct, $urandom_range(99) < case_pct,
                            i == len - 1);
            sent += len;
            if ($urandom_range(19) == 0)
                hold_until_drained();
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: threshold near 0.1, all samples pooled
        send_sample(1'b0, 1'b1, 1'b1);
        send_sample(1'b1, 1'b0, 1'b1);
        // one missing in ten sits just under the reset threshold
        for (int i = 0; i < 9; i++)
            send_sample(1'b0, i[0], 1'b0);
        send_sample(1'b1, 1'b1, 1'b1);

        // zero threshold, per class: clean variant kept, empty control class
        set_filter(0, 1'b1);
        send_sample(1'b0, 1'b1, 1'b0);
        send_sample(1'b0, 1'b0, 1'b1);
        send_sample(1'b1, 1'b1, 1'b1);

        // exactly at the threshold does not fail
        set_filter(32768, 1'b1);
        send_sample(1'b1, 1'b1, 1'b0);
        send_sample(1'b0, 1'b1, 1'b1);

        // threshold above one and at one: everything missing still kept
        set_filter(131071, 1'b0);
        send_sample(1'b1, 1'b0, 1'b0);
        send_sample(1'b1, 1'b1, 1'b1);
        set_filter(65536, 1'b0);
        send_sample(1'b1, 1'b0, 1'b1);

        for (int p = 0; p < 3; p++) begin
            case (p)
                0:       begin tx_idle_pct = 29; rx_idle_pct = 48; end
                1:       begin tx_idle_pct = 48; rx_idle_pct = 29; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            for (int seg = 0; seg < 6; seg++)
                random_segment(95);
        end

        hold_until_drained();
        repeat (8) @(posedge aclk);

        $display("covered %0d sample words in %0d variants, pooled and per-class tests,",
                 n_words, n_variants);
        $display("thresholds from zero to above one, and mixed gaps and stalls");
        if (errors == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: missing_rate_variant_filter.f
sv/mrvf_pkg.sv
sv/mrvf_judge.sv
sv/missing_rate_variant_filter.sv
bench/mrvf_checker.sv
bench/missing_rate_variant_filter_tb.sv
